// ===== hw/rtl/lcdws_pkg.sv =====
// Shared request codes and bus constants for the character-LCD write sequencer.
`default_nettype none

package lcdws_pkg;

  // Request kinds carried on func.
  localparam logic [2:0] FUNC_INIT  = 3'd0;
  localparam logic [2:0] FUNC_CMD   = 3'd1;
  localparam logic [2:0] FUNC_DATA  = 3'd2;
  localparam logic [2:0] FUNC_POS   = 3'd3;
  localparam logic [2:0] FUNC_NUM   = 3'd4;
  localparam logic [2:0] FUNC_GLYPH = 3'd5;

  // Controller commands used by the init sequence.
  localparam logic [7:0] CMD_FUNCSET = 8'h38;
  localparam logic [7:0] CMD_DISPON  = 8'h0C;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic [5:0] INIT_WAIT_MS = 6'd40;
  localparam logic [1:0] SETTLE_SHORT = 2'd1;
  localparam logic [1:0] SETTLE_CLEAR = 2'd2;

  // Largest number of decimal digits sent for one number request.
  localparam int unsigned MaxDigits = 5;

  // floor(v / 10) == (v * DivTenMul) >> DivTenShift for every 16-bit v.
  localparam logic [15:0] DivTenMul   = 16'hCCCD;
  localparam int unsigned DivTenShift = 19;

endpackage

`default_nettype wire

// ===== hw/rtl/char_lcd_write_sequencer_top.sv =====
// Turns one LCD request item into a run of 8-bit character-LCD bus writes.
// The first write of an item follows accept through state_q and then strobe_q (a number item
// first converts one decimal digit per cycle in the shared divide-by-ten step); then writes
// come one per cycle: init three, glyph ten, command, data and position one, unused codes none.
// busy is high while an item is converted or emitted; the receiver cannot stall the writes.
// Reset (asynchronous, active low) returns the sequencer to idle with no strobe pending.
`default_nettype none

module char_lcd_write_sequencer_top
  import lcdws_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func_i,
  input  wire logic [15:0] value_in_i,
  input  wire logic        row_i,
  input  wire logic [5:0]  column_i,
  input  wire logic [2:0]  glyph_slot_i,
  input  wire logic [39:0] glyph_rows_i,
  output logic             strobe_o,
  output logic             lcd_rs_o,
  output logic [7:0]       lcd_byte_o,
  output logic [5:0]       wait_before_ms_o,
  output logic [1:0]       settle_ms_o,
  output logic             last_o
);

  localparam int unsigned DigCntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned DigIdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  last_idx_q, last_idx_d;

  // Request payload, held for the whole item.
  logic [2:0]  func_q;
  logic [7:0]  byte_q;
  logic [7:0]  pos_q;
  logic [2:0]  slot_q;
  logic [4:0]  rows_q [8];

  // Decimal conversion.
  logic [15:0]        val_q;
  logic [DigCntW-1:0] ndig_q;
  logic [3:0]         digits_q [MAX_DIGITS];

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] rem16;
  logic [DigCntW-1:0] ndig_inc;
  logic        conv_done;

  logic        accept;
  logic        emit_last;
  logic        w_rs;
  logic [7:0]  w_byte;
  logic [5:0]  w_wait;
  logic [1:0]  w_settle;
  logic [3:0]  grow_idx;

  logic        strobe_q;
  logic        rs_q;
  logic [7:0]  out_byte_q;
  logic [5:0]  wait_q;
  logic [1:0]  settle_q;
  logic        last_q;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // One shared divide-by-ten step: reciprocal multiply, then remainder by shift-add.
  assign prod      = {16'd0, val_q} * {16'd0, DivTenMul};
  assign quot      = 16'(prod >> DivTenShift);
  assign rem16     = val_q - ((quot << 3) + (quot << 1));
  assign ndig_inc  = ndig_q + DigCntW'(1);
  assign conv_done = (quot == 16'd0) || (ndig_inc == DigCntW'(MAX_DIGITS));

  assign grow_idx  = idx_q - 4'd1;

  // Current bus write while emitting.
  always_comb begin
    w_rs     = 1'b0;
    w_byte   = 8'h00;
    w_wait   = 6'd0;
    w_settle = 2'd0;
    case (func_q)
      FUNC_INIT: begin
        case (idx_q)
          4'd0: begin
            w_byte   = CMD_FUNCSET;
            w_wait   = INIT_WAIT_MS;
            w_settle = SETTLE_SHORT;
          end
          4'd1: begin
            w_byte   = CMD_DISPON;
            w_settle = SETTLE_SHORT;
          end
          default: begin
            w_byte   = CMD_CLEAR;
            w_settle = SETTLE_CLEAR;
          end
        endcase
      end
      FUNC_CMD: w_byte = byte_q;
      FUNC_DATA: begin
        w_rs   = 1'b1;
        w_byte = byte_q;
      end
      FUNC_POS: w_byte = pos_q;
      FUNC_NUM: begin
        w_rs   = 1'b1;
        w_byte = ASCII_ZERO + {4'd0, digits_q[idx_q[DigIdxW-1:0]]};
      end
      FUNC_GLYPH: begin
        if (idx_q == 4'd0) begin
          w_byte = {2'b01, slot_q, 3'b000};
        end else if (idx_q == 4'd9) begin
          w_byte = pos_q;
        end else begin
          w_rs   = 1'b1;
          w_byte = {3'd0, rows_q[grow_idx[2:0]]};
        end
      end
      default: w_byte = 8'h00;
    endcase
  end

  // Number digits are sent from the most significant one down to index zero.
  assign emit_last = (func_q == FUNC_NUM) ? (idx_q == 4'd0) : (idx_q == last_idx_q);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          idx_d = 4'd0;
          case (func_i)
            FUNC_INIT: begin
              last_idx_d = 4'd2;
              state_d    = S_EMIT;
            end
            FUNC_CMD, FUNC_DATA, FUNC_POS: begin
              last_idx_d = 4'd0;
              state_d    = S_EMIT;
            end
            FUNC_NUM: state_d = S_CONV;
            FUNC_GLYPH: begin
              last_idx_d = 4'd9;
              state_d    = S_EMIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        if (conv_done) begin
          idx_d   = 4'(ndig_q);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_last) begin
          state_d = S_IDLE;
        end else if (func_q == FUNC_NUM) begin
          idx_d = idx_q - 4'd1;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= 4'd0;
      last_idx_q <= 4'd0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
      strobe_q   <= (state_q == S_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      byte_q <= value_in_i[7:0];
      pos_q  <= {1'b1, row_i, column_i};
      slot_q <= glyph_slot_i;
      for (int i = 0; i < 8; i++) begin
        rows_q[i] <= glyph_rows_i[5*i +: 5];
      end
      val_q  <= value_in_i;
      ndig_q <= '0;
    end else if (state_q == S_CONV) begin
      digits_q[ndig_q[DigIdxW-1:0]] <= rem16[3:0];
      val_q  <= quot;
      ndig_q <= ndig_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q       <= w_rs;
    out_byte_q <= w_byte;
    wait_q     <= w_wait;
    settle_q   <= w_settle;
    last_q     <= emit_last;
  end

  assign strobe_o         = strobe_q;
  assign lcd_rs_o         = rs_q;
  assign lcd_byte_o       = out_byte_q;
  assign wait_before_ms_o = wait_q;
  assign settle_ms_o      = settle_q;
  assign last_o           = last_q;

  // A write is only ever produced by a cycle spent emitting.
  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(state_q == S_EMIT))
    else $error("strobe without an emit cycle");

  // Writes of one item come out back to back until the last one.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("gap inside a write run");

  // The last write of an item is never followed directly by another write.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o)
    else $error("write right after the last write of an item");

  // A digit write always carries an ASCII decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && func_q == FUNC_NUM) |-> (w_byte >= 8'h30 && w_byte <= 8'h39))
    else $error("digit out of range");

endmodule

`default_nettype wire
